// File: rtl/ubxfr_pkg.sv
// Shared types and constants of the UBX frame receiver.
package ubxfr_pkg;

    // Frame markers.
    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam logic [7:0] IDLE_BYTE   = 8'hFF;

    // Idle limit after reset.
    localparam logic [7:0] IDLE_LIMIT_RESET = 8'd200;

    // Largest payload accepted, and the width of a length that fits it.
    localparam int MAX_PAYLOAD = 1024;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam logic [15:0] MAX_LEN16 = 16'(MAX_PAYLOAD);

    // Width of the reported payload position.
    localparam int IDX_W = 10;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_DATA    = 3'd0,
        KIND_GOOD    = 3'd1,
        KIND_CKERR   = 3'd2,
        KIND_TIMEOUT = 3'd3,
        KIND_TOOLONG = 3'd4
    } kind_t;

    // One result item, with a flag that says whether the byte made one.
    typedef struct packed {
        logic             valid;
        kind_t            kind;
        logic [7:0]       msg_class;
        logic [7:0]       msg_id;
        logic [7:0]       data_byte;
        logic [IDX_W-1:0] byte_index;
        logic             frame_last;
    } res_t;

endpackage

// File: rtl/ubxfr_parser.sv
// Frame parser: sync hunt, header capture, Fletcher-8 sums and result build.
module ubxfr_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        idle_limit,
    output ubxfr_pkg::res_t   res
);
    import ubxfr_pkg::*;

    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_CLASS   = 3'd2,
        PH_ID      = 3'd3,
        PH_LEN_LO  = 3'd4,
        PH_LEN_HI  = 3'd5,
        PH_PAYLOAD = 3'd6,
        PH_CKA     = 3'd7
    } phase_t;

    // A separate flag marks the second check byte so that the phase fits
    // its eight codes; it is set only while the phase stays at PH_CKA.
    phase_t           phase_reg, phase_next;
    logic             ckb_reg, ckb_next;
    logic [7:0]       idle_count_reg, idle_count_next;
    logic [7:0]       sum_a_reg, sum_a_next;
    logic [7:0]       sum_b_reg, sum_b_next;
    logic [7:0]       class_reg, class_next;
    logic [7:0]       id_reg, id_next;
    logic [7:0]       len_lo_reg, len_lo_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [7:0]       ck_a_reg, ck_a_next;

    logic [7:0]       sum_a_add;
    logic [7:0]       sum_b_add;
    logic [7:0]       idle_inc;
    logic [15:0]      len_full;
    logic [LEN_W-1:0] pos_inc;

    // Running sums for the byte at hand.
    assign sum_a_add = sum_a_reg + rx_byte;
    assign sum_b_add = sum_b_reg + sum_a_add;
    assign idle_inc  = (idle_count_reg == 8'hFF) ? idle_count_reg : idle_count_reg + 8'd1;
    assign len_full  = {rx_byte, len_lo_reg};
    assign pos_inc   = pos_reg + LEN_W'(1);

    // Next state and result for one byte.
    always_comb
    begin
        phase_next      = phase_reg;
        ckb_next        = ckb_reg;
        idle_count_next = idle_count_reg;
        sum_a_next      = sum_a_reg;
        sum_b_next      = sum_b_reg;
        class_next      = class_reg;
        id_next         = id_reg;
        len_lo_next     = len_lo_reg;
        len_next        = len_reg;
        pos_next        = pos_reg;
        ck_a_next       = ck_a_reg;
        res             = '0;

        case (phase_reg)
            PH_SYNC1:
            begin
                if (rx_byte == SYNC_FIRST)
                begin
                    phase_next = PH_SYNC2;
                end
                else if (rx_byte == IDLE_BYTE)
                begin
                    idle_count_next = idle_inc;
                    if (idle_inc >= idle_limit)
                    begin
                        idle_count_next = '0;
                        res.valid       = 1'b1;
                        res.kind        = KIND_TIMEOUT;
                        res.frame_last  = 1'b1;
                    end
                end
            end
            PH_SYNC2:
            begin
                if (rx_byte == SYNC_SECOND)
                begin
                    idle_count_next = '0;
                    sum_a_next      = '0;
                    sum_b_next      = '0;
                    phase_next      = PH_CLASS;
                end
                else
                begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_CLASS:
            begin
                class_next = rx_byte;
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                phase_next = PH_ID;
            end
            PH_ID:
            begin
                id_next    = rx_byte;
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                len_lo_next = rx_byte;
                sum_a_next  = sum_a_add;
                sum_b_next  = sum_b_add;
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                pos_next   = '0;
                len_next   = LEN_W'(len_full);
                if (len_full > MAX_LEN16)
                begin
                    res.valid      = 1'b1;
                    res.kind       = KIND_TOOLONG;
                    res.msg_class  = class_reg;
                    res.msg_id     = id_reg;
                    res.frame_last = 1'b1;
                    phase_next     = PH_SYNC1;
                end
                else if (len_full == 16'd0)
                begin
                    phase_next = PH_CKA;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                sum_a_next     = sum_a_add;
                sum_b_next     = sum_b_add;
                res.valid      = 1'b1;
                res.kind       = KIND_DATA;
                res.msg_class  = class_reg;
                res.msg_id     = id_reg;
                res.data_byte  = rx_byte;
                res.byte_index = IDX_W'(pos_reg);
                pos_next       = pos_inc;
                if (pos_inc >= len_reg)
                begin
                    phase_next = PH_CKA;
                end
            end
            PH_CKA:
            begin
                if (!ckb_reg)
                begin
                    // First check byte: hold it for the compare.
                    ck_a_next = rx_byte;
                    ckb_next  = 1'b1;
                end
                else
                begin
                    // Second check byte closes the frame.
                    res.valid      = 1'b1;
                    res.msg_class  = class_reg;
                    res.msg_id     = id_reg;
                    res.frame_last = 1'b1;
                    res.kind       = (ck_a_reg == sum_a_reg && rx_byte == sum_b_reg) ?
                                     KIND_GOOD : KIND_CKERR;
                    ckb_next       = 1'b0;
                    phase_next     = PH_SYNC1;
                end
            end
            default:
            begin
                phase_next = PH_SYNC1;
            end
        endcase
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SYNC1;
            ckb_reg        <= 1'b0;
            idle_count_reg <= '0;
            sum_a_reg      <= '0;
            sum_b_reg      <= '0;
            class_reg      <= '0;
            id_reg         <= '0;
            len_lo_reg     <= '0;
            len_reg        <= '0;
            pos_reg        <= '0;
            ck_a_reg       <= '0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            ckb_reg        <= ckb_next;
            idle_count_reg <= idle_count_next;
            sum_a_reg      <= sum_a_next;
            sum_b_reg      <= sum_b_next;
            class_reg      <= class_next;
            id_reg         <= id_next;
            len_lo_reg     <= len_lo_next;
            len_reg        <= len_next;
            pos_reg        <= pos_next;
            ck_a_reg       <= ck_a_next;
        end
    end

    // A completed sync pair starts the sums from zero and clears the idle count.
    a_sync_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg == PH_SYNC2 && rx_byte == SYNC_SECOND
        |=> sum_a_reg == 8'd0 && sum_b_reg == 8'd0 && idle_count_reg == 8'd0)
        else $error("sync pair did not clear the sums and idle count");

    // Inside the payload the position stays below an accepted length.
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> pos_reg < len_reg && len_reg <= LEN_W'(MAX_PAYLOAD))
        else $error("payload position or length out of range");

    // Only status results end a frame.
    a_last_marks_status: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.valid |-> res.frame_last == (res.kind != KIND_DATA))
        else $error("frame_last does not match the result kind");

    // The second check byte flag is only ever set while waiting for check bytes.
    a_ckb_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ckb_reg |-> phase_reg == PH_CKA)
        else $error("check byte flag set outside the check phase");

endmodule

// File: rtl/ubx_frame_receiver_core.sv
// Top level of the UBX frame receiver: stream ports, idle limit register, item stages.
//
// Usage:
//   Raw link bytes enter on the s_axis channel, one byte per item. Each byte
//   is parsed for the UBX sync pair, header, payload and Fletcher-8 check.
//   Results leave on the m_axis channel: a payload byte item for every
//   payload byte, and a status item (frame good, checksum error, idle
//   timeout, length too large) with tlast high. Header and first check bytes
//   and hunting bytes without a timeout produce no result.
//   A result passes through one input register, then the parser logic feeds the
//   output register. Throughput is one byte per cycle while the output is not
//   stalled; the parser and its state registers handle each byte as it leaves
//   the input register.
//   When m_axis_tready is low with a result waiting, the input register
//   still takes one more byte, then s_axis_tready drops until the result
//   is taken.
//   The user must write the idle limit with cfg_we/cfg_wdata only while the block
//   is idle; the block itself does not enforce this. Reset clears the stages,
//   returns the parser to hunting for sync and sets the idle limit to 200.
module ubx_frame_receiver_core (
    input  logic        clk,
    input  logic        rst_n,
    // Input items: rx_byte [7:0].
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    // Result items: msg_class [7:0], msg_id [15:8], data_byte [23:16],
    // byte_index [33:24], zero [39:34].
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,
    // kind [2:0].
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    // Idle limit register write.
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);
    import ubxfr_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    res_t       out_res_reg;
    logic [7:0] idle_limit_reg;
    logic       advance;
    res_t       res;

    // The input register moves on when the output register is free or being emptied.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign in_valid_next  = (s_axis_tvalid && s_axis_tready) || (in_valid_reg && !advance);
    assign out_valid_next = advance ? res.valid : (out_valid_reg && !m_axis_tready);

    ubxfr_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .rx_byte    (in_byte_reg),
        .idle_limit (idle_limit_reg),
        .res        (res)
    );

    // Control state and the idle limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            idle_limit_reg <= IDLE_LIMIT_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                idle_limit_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance && res.valid)
        begin
            out_res_reg <= res;
        end
    end

    // Result packing.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_res_reg.byte_index, out_res_reg.data_byte,
                            out_res_reg.msg_id, out_res_reg.msg_class};
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tlast  = out_res_reg.frame_last;

endmodule

// File: bench/ubx_frame_receiver_checker.sv
// Scoreboard for the UBX frame receiver: tracks input bytes, predicts the result items, compares.
module ubx_frame_receiver_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    output int          mismatch_count,
    output int          outstanding_reports,
    output int          reports_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import ubxfr_pkg::*;

    // Parser phases, in the order a frame walks through them.
    typedef enum logic [2:0] {
        HUNT_SYNC1  = 3'd0,
        HUNT_SYNC2  = 3'd1,
        GET_CLASS   = 3'd2,
        GET_ID      = 3'd3,
        GET_LEN     = 3'd4,
        GET_PAYLOAD = 3'd5,
        GET_CK_A    = 3'd6,
        GET_CK_B    = 3'd7
    } parse_phase_t;

    // One report the receiver is expected to emit.
    typedef struct {
        kind_t            kind;
        logic [7:0]       msg_class;
        logic [7:0]       msg_id;
        logic [7:0]       data_byte;
        logic [IDX_W-1:0] byte_index;
        logic             frame_last;
    } ubx_report_t;

    parse_phase_t phase;
    logic [7:0]   idle_limit;
    logic [7:0]   idle_run;
    logic [7:0]   fletch_a;
    logic [7:0]   fletch_b;
    logic [7:0]   frame_class;
    logic [7:0]   frame_id;
    logic [7:0]   rx_ck_a;
    logic [15:0]  frame_len;
    logic [15:0]  frame_pos;
    ubx_report_t  pending_reports[$];

    // Running Fletcher-8 sums over class, id, length and payload.
    task automatic add_to_sums(input logic [7:0] b);
        fletch_a = fletch_a + b;
        fletch_b = fletch_b + fletch_a;
    endtask

    // Advance the parser by one received byte and queue any report it causes.
    task automatic track_frame_byte(input logic [7:0] b);
        ubx_report_t rep;
        logic        emit;
        emit           = 1'b0;
        rep.kind       = KIND_DATA;
        rep.msg_class  = frame_class;
        rep.msg_id     = frame_id;
        rep.data_byte  = 8'h00;
        rep.byte_index = '0;
        rep.frame_last = 1'b1;
        case (phase)
            HUNT_SYNC1:
            begin
                if (b == SYNC_FIRST)
                begin
                    phase = HUNT_SYNC2;
                end
                else if (b == IDLE_BYTE)
                begin
                    if (idle_run != 8'hFF)
                        idle_run = idle_run + 8'd1;
                    // A limit of zero behaves like one since the test is >=.
                    if (idle_run >= idle_limit)
                    begin
                        idle_run      = 8'h00;
                        rep.kind      = KIND_TIMEOUT;
                        rep.msg_class = 8'h00;
                        rep.msg_id    = 8'h00;
                        emit          = 1'b1;
                    end
                end
            end
            HUNT_SYNC2:
            begin
                // Anything but the second sync byte is dropped uncounted.
                if (b == SYNC_SECOND)
                begin
                    idle_run = 8'h00;
                    fletch_a = 8'h00;
                    fletch_b = 8'h00;
                    phase    = GET_CLASS;
                end
                else
                begin
                    phase = HUNT_SYNC1;
                end
            end
            GET_CLASS:
            begin
                frame_class = b;
                add_to_sums(b);
                phase = GET_ID;
            end
            GET_ID:
            begin
                frame_id = b;
                add_to_sums(b);
                frame_pos = 16'd0;
                phase     = GET_LEN;
            end
            GET_LEN:
            begin
                add_to_sums(b);
                if (frame_pos == 16'd0)
                begin
                    frame_len = {8'h00, b};
                    frame_pos = 16'd1;
                end
                else
                begin
                    frame_len = {b, frame_len[7:0]};
                    frame_pos = 16'd0;
                    if (frame_len > MAX_LEN16)
                    begin
                        rep.kind      = KIND_TOOLONG;
                        rep.msg_class = frame_class;
                        rep.msg_id    = frame_id;
                        emit          = 1'b1;
                        phase         = HUNT_SYNC1;
                    end
                    else if (frame_len == 16'd0)
                    begin
                        phase = GET_CK_A;
                    end
                    else
                    begin
                        phase = GET_PAYLOAD;
                    end
                end
            end
            GET_PAYLOAD:
            begin
                add_to_sums(b);
                rep.kind       = KIND_DATA;
                rep.data_byte  = b;
                rep.byte_index = frame_pos[IDX_W-1:0];
                rep.frame_last = 1'b0;
                emit           = 1'b1;
                frame_pos      = frame_pos + 16'd1;
                if (frame_pos >= frame_len)
                    phase = GET_CK_A;
            end
            GET_CK_A:
            begin
                rx_ck_a = b;
                phase   = GET_CK_B;
            end
            default:
            begin
                if (rx_ck_a == fletch_a && b == fletch_b)
                    rep.kind = KIND_GOOD;
                else
                    rep.kind = KIND_CKERR;
                emit  = 1'b1;
                phase = HUNT_SYNC1;
            end
        endcase
        if (emit)
            pending_reports.push_back(rep);
    endtask

    task automatic check_field(input string name, input int unsigned expv,
                               input int unsigned actv);
        if (expv != actv)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
            mismatch_count++;
        end
    endtask

    // Follow both channels and the limit register at every clock edge.
    always @(posedge clk or negedge rst_n)
    begin
        ubx_report_t want;
        if (!rst_n)
        begin
            phase       = HUNT_SYNC1;
            idle_limit  = IDLE_LIMIT_RESET;
            idle_run    = 8'h00;
            fletch_a    = 8'h00;
            fletch_b    = 8'h00;
            frame_class = 8'h00;
            frame_id    = 8'h00;
            rx_ck_a     = 8'h00;
            frame_len   = 16'd0;
            frame_pos   = 16'd0;
            pending_reports.delete();
            mismatch_count      = 0;
            reports_checked     = 0;
            outstanding_reports <= 0;
        end
        else
        begin
            if (cfg_we)
                idle_limit = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                track_frame_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("unexpected result item: kind %0d, tdata %h",
                           m_axis_tuser, m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    reports_checked++;
                    check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
                    check_field("msg_class", 32'(want.msg_class), 32'(m_axis_tdata[7:0]));
                    check_field("msg_id", 32'(want.msg_id), 32'(m_axis_tdata[15:8]));
                    check_field("data_byte", 32'(want.data_byte),
                                32'(m_axis_tdata[23:16]));
                    check_field("byte_index", 32'(want.byte_index),
                                32'(m_axis_tdata[33:24]));
                    check_field("frame_last", 32'(want.frame_last), 32'(m_axis_tlast));
                end
            end
            outstanding_reports <= pending_reports.size();
        end
    end

endmodule

// File: bench/ubx_frame_receiver_core_tb.sv
// Testbench top for the UBX frame receiver: byte stimulus, output stalls and the verdict.
module ubx_frame_receiver_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ubxfr_pkg::*;

    localparam int RUN_CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES    = 6;
    localparam int RANDOM_BYTES    = 1100;
    localparam int LIMIT_SETTINGS  = 6;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_we        = 1'b0;
    logic [7:0]  cfg_wdata     = 8'h00;

    int mismatch_count;
    int outstanding_reports;
    int reports_checked;

    int         cycle_count    = 0;
    int         bytes_sent     = 0;
    int         ignored_bytes  = 0;
    int         frames_sent    = 0;
    int         oversize_sent  = 0;
    int         idle_runs_sent = 0;
    int         free_run_left  = 0;
    int         ready_hold     = 0;
    int         ready_pick;
    logic [7:0] stim_idle_limit = IDLE_LIMIT_RESET;
    logic [7:0] run_a;
    logic [7:0] run_b;
    logic [7:0] frame_body[$];

    ubx_frame_receiver_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    ubx_frame_receiver_checker scoreboard (
        .clk                 (clk),
        .rst_n               (rst_n),
        .s_axis_tvalid       (s_axis_tvalid),
        .s_axis_tready       (s_axis_tready),
        .s_axis_tdata        (s_axis_tdata),
        .m_axis_tvalid       (m_axis_tvalid),
        .m_axis_tready       (m_axis_tready),
        .m_axis_tdata        (m_axis_tdata),
        .m_axis_tuser        (m_axis_tuser),
        .m_axis_tlast        (m_axis_tlast),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .mismatch_count      (mismatch_count),
        .outstanding_reports (outstanding_reports),
        .reports_checked     (reports_checked)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= RUN_CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, outstanding_reports);
            $display("ubx_frame_receiver_core_tb: FAIL");
            $finish;
        end
    end

    // Result side: ready runs and stalls, mostly short with a few long ones.
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
        end
        else
        begin
            ready_pick = $urandom_range(0, 99);
            if (ready_pick < 60)
            begin
                m_axis_tready <= 1'b1;
                ready_hold = (ready_pick < 6) ? $urandom_range(40, 150) : $urandom_range(0, 8);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                ready_hold = (ready_pick >= 95) ? $urandom_range(10, 60) : $urandom_range(0, 3);
            end
        end
    end

    // Present one byte after a random gap and wait until it is accepted.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        int pick;
        if (free_run_left > 0)
        begin
            free_run_left--;
            gap = 0;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
            begin
                free_run_left = $urandom_range(30, 120);
                gap = 0;
            end
            else if (pick < 55)
                gap = 0;
            else if (pick < 93)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(6, 40);
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_sent++;
    endtask

    // Send a byte that is covered by the Fletcher sums.
    task automatic send_summed(input logic [7:0] b);
        run_a = run_a + b;
        run_b = run_b + run_a;
        send_byte(b);
    endtask

    // Send sync, header, frame_body and check bytes. An oversize length stops
    // after the header. ck_fault 1 spoils ck_a, 2 spoils ck_b.
    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len, input int ck_fault);
        run_a = 8'h00;
        run_b = 8'h00;
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_summed(cls);
        send_summed(id);
        send_summed(len[7:0]);
        send_summed(len[15:8]);
        if (len > MAX_LEN16)
        begin
            oversize_sent++;
        end
        else
        begin
            foreach (frame_body[i])
                send_summed(frame_body[i]);
            send_byte((ck_fault == 1) ? run_a ^ 8'($urandom_range(1, 255)) : run_a);
            send_byte((ck_fault == 2) ? run_b ^ 8'($urandom_range(1, 255)) : run_b);
            frames_sent++;
        end
    endtask

    task automatic fill_body(input int len);
        frame_body.delete();
        repeat (len) frame_body.push_back(8'($urandom_range(0, 255)));
    endtask

    // Header bytes lean toward the extremes now and then.
    function automatic logic [7:0] pick_header_byte();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 8'h00;
        else if (pick == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Stop driving and wait until every expected result has come out and
    // the pipeline has had time to finish any byte that causes no result.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding_reports != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_idle_limit(input logic [7:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        stim_idle_limit = value;
    endtask

    // One random stretch of link traffic: mostly well-formed frames with
    // random content, plus oversize headers, idle runs, noise and broken syncs.
    task automatic send_random_unit();
        int         pick;
        int         len;
        int         n;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 62)
        begin
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 80);
            fill_body(len);
            n = $urandom_range(0, 99);
            send_frame(pick_header_byte(), pick_header_byte(), 16'(len),
                       (n < 75) ? 0 : ((n < 87) ? 1 : 2));
        end
        else if (pick < 70)
        begin
            n = $urandom_range(0, 9);
            if (n < 2)
                len = MAX_PAYLOAD + 1;
            else if (n < 4)
                len = 16'hFFFF;
            else
                len = $urandom_range(MAX_PAYLOAD + 1, 16'hFFFF);
            send_frame(pick_header_byte(), pick_header_byte(), 16'(len), 0);
        end
        else if (pick < 80)
        begin
            // Idle runs reach past the limit only some of the time.
            if ($urandom_range(0, 1) == 0)
                n = $urandom_range(1, 5);
            else
                n = $urandom_range(1, int'(stim_idle_limit) + 2);
            repeat (n) send_byte(IDLE_BYTE);
            idle_runs_sent++;
        end
        else if (pick < 90)
        begin
            n = $urandom_range(1, 8);
            repeat (n)
            begin
                case ($urandom_range(0, 9))
                    0: b = SYNC_FIRST;
                    1: b = SYNC_SECOND;
                    2: b = IDLE_BYTE;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_byte(b);
                if (b != IDLE_BYTE)
                    ignored_bytes++;
            end
        end
        else
        begin
            // Broken syncs: a wrong second byte, or a sync pair followed by
            // a truncated header that the parser treats as a new frame.
            send_byte(SYNC_FIRST);
            if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: b = SYNC_FIRST;
                    1: b = IDLE_BYTE;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                if (b == SYNC_SECOND)
                    b = 8'h00;
                send_byte(b);
                ignored_bytes += 2;
            end
            else
            begin
                send_byte(SYNC_SECOND);
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic run_random_phase();
        int start_count;
        start_count = bytes_sent - ignored_bytes;
        while ((bytes_sent - ignored_bytes) - start_count < RANDOM_BYTES / LIMIT_SETTINGS)
            send_random_unit();
    endtask

    // Main sequence: reset, directed frames, then random traffic under
    // several idle limit settings.
    initial
    begin
        logic [7:0] limit_values[LIMIT_SETTINGS-1];
        limit_values[0] = 8'd1;
        limit_values[1] = 8'd0;
        limit_values[2] = 8'd255;
        limit_values[3] = 8'($urandom_range(2, 254));
        limit_values[4] = 8'd3;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero-length frame with extreme class and id, checksum good.
        frame_body.delete();
        send_frame(8'h00, 8'hFF, 16'd0, 0);
        // Two payload bytes at the extremes, with a bad ck_b.
        frame_body.delete();
        frame_body.push_back(8'h00);
        frame_body.push_back(8'hFF);
        send_frame(8'hFF, 8'h00, 16'd2, 2);
        // Wrong second sync byte, an idle byte that must not count.
        send_byte(SYNC_FIRST);
        send_byte(IDLE_BYTE);
        // Length one past the largest payload.
        send_frame(8'h01, 8'h02, 16'(MAX_PAYLOAD + 1), 0);

        run_random_phase();
        for (int p = 0; p < LIMIT_SETTINGS - 1; p++)
        begin
            write_idle_limit(limit_values[p]);
            run_random_phase();
        end

        drain();
        $display("covered %0d input items: %0d checked frames, %0d oversize headers, %0d idle runs",
                 bytes_sent, frames_sent, oversize_sent, idle_runs_sent);
        $display("%0d idle limit settings, %0d result items compared, %0d mismatches",
                 LIMIT_SETTINGS, reports_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("ubx_frame_receiver_core_tb: PASS");
        else
            $display("ubx_frame_receiver_core_tb: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/ubxfr_pkg.sv
rtl/ubxfr_parser.sv
rtl/ubx_frame_receiver_core.sv
bench/ubx_frame_receiver_checker.sv
bench/ubx_frame_receiver_core_tb.sv
